>>> sv/pss_pkg.sv
package pss_pkg;

  localparam int DefCapacity = 64;
  localparam int DATA_W      = 32;
  localparam int POS_W       = 7;
  localparam int OP_W        = 3;
  localparam int ST_W        = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_ERASE   = 3'd1,
    OP_READ    = 3'd2,
    OP_WRITE   = 3'd3,
    OP_REVERSE = 3'd4,
    OP_CLEAR   = 3'd5
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // what every cell is told to do on a clock edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN,
    CELL_WRITE
  } cell_op_t;

  typedef struct packed {
    cell_op_t            kind;
    logic [DATA_W-1:0]   data;
  } cell_cmd_t;

endpackage

>>> sv/pss_cell.sv
module pss_cell
  import pss_pkg::*;
#(
  parameter int IdxW = 6,
  parameter int Idx  = 0
) (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [IdxW-1:0]   target,
  input  logic [DATA_W-1:0] left,
  input  logic [DATA_W-1:0] right,
  output logic [DATA_W-1:0] value,
  output logic [DATA_W-1:0] rd
);

  logic [DATA_W-1:0] value_r;
  logic [DATA_W-1:0] value_nxt;
  logic              hit;
  logic              above;

  assign hit   = (target == IdxW'(Idx));
  assign above = (IdxW'(Idx) > target);

  always_comb begin
    value_nxt = value_r;
    case (cmd.kind)
      CELL_SHIFT_UP: begin
        if (above) begin
          value_nxt = left;
        end else if (hit) begin
          value_nxt = cmd.data;
        end
      end
      CELL_SHIFT_DOWN: begin
        if (above || hit) begin
          value_nxt = right;
        end
      end
      CELL_WRITE: begin
        if (hit) begin
          value_nxt = cmd.data;
        end
      end
      default: begin
        value_nxt = value_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;
  assign rd    = hit ? value_r : '0;

endmodule

>>> sv/positional_sequence_store.sv
// positional sequence store: ordered list of signed 32-bit values addressed by position
// in channel: one request per transfer, in_tuser carries the operation code,
//   in_tdata carries position and data_in
// out channel: one result per request with the value read, the count after the
//   operation and a status code in out_tuser
// the result is registered and shows on out_tvalid in the cycle after an input transfer
// throughput: one request per cycle while the receiver keeps up; every element sits in
//   a cell of its own and insert and erase shift the cells at and above the target
//   position toward or from their neighbor in that same cycle, while reverse only
//   flips the direction in which positions are counted
// a stalled receiver holds the result register; a new request is taken in the
//   cycle the pending result is transferred, so a stall holds off the input as well
// reset clears the count, the direction flag and the output valid; the cell
//   contents are not cleared since no position at or beyond the count is ever read
module positional_sequence_store
  import pss_pkg::*;
#(
  parameter int CAPACITY = DefCapacity
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [6:0] position, [38:7] data_in, [39] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [2:0] operation
  input  logic [OP_W-1:0]        in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [31:0] data_out, [38:32] count, [39] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [1:0] status
  output logic [ST_W-1:0]        out_tuser
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int IdxW = $clog2(CAPACITY);
  localparam int CmpW = (CntW > POS_W) ? CntW : POS_W;
  localparam int PadW = OUT_TDATA_W - DATA_W - POS_W;

  // list state: count of held elements and the direction flag
  logic [CntW-1:0]   count_r;
  logic [CntW-1:0]   count_nxt;
  logic              rev_r;
  logic              rev_nxt;

  // result register
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [DATA_W-1:0] out_data_r;
  logic [CntW-1:0]   out_count_r;
  status_t           out_status_r;

  logic              fire;
  op_t               op;
  logic [POS_W-1:0]  pos;
  logic [DATA_W-1:0] din;
  logic [CmpW-1:0]   pos_x;
  logic [CmpW-1:0]   n_x;
  logic [CmpW-1:0]   cap_x;
  logic [CmpW-1:0]   at_ins;
  logic [CmpW-1:0]   at_idx;
  logic [IdxW-1:0]   target;
  cell_op_t          kind;
  cell_cmd_t         cmd;
  status_t           status;
  logic              rd_en;
  logic [DATA_W-1:0] rd_data;

  logic [DATA_W-1:0] cell_val [CAPACITY];
  logic [DATA_W-1:0] cell_rd  [CAPACITY];

  assign in_tready = !out_valid_r || out_tready;
  assign fire      = in_tvalid && in_tready;

  assign op  = op_t'(in_tuser);
  assign pos = in_tdata[POS_W-1:0];
  assign din = in_tdata[POS_W +: DATA_W];

  assign pos_x = CmpW'(pos);
  assign n_x   = CmpW'(count_r);
  assign cap_x = CmpW'(CAPACITY);

  // with the direction flag set, logical position p lives at physical n-1-p,
  // and an insert at p lands at physical n-p with the cells above moving up
  assign at_ins = rev_r ? (n_x - pos_x) : pos_x;
  assign at_idx = rev_r ? (n_x - pos_x - CmpW'(1)) : pos_x;
  assign target = (op == OP_INSERT) ? at_ins[IdxW-1:0] : at_idx[IdxW-1:0];

  always_comb begin
    kind      = CELL_HOLD;
    status    = ST_DONE;
    rd_en     = 1'b0;
    count_nxt = count_r;
    rev_nxt   = rev_r;
    case (op)
      OP_INSERT: begin
        if (pos_x > n_x) begin
          status = ST_RANGE;
        end else if (n_x >= cap_x) begin
          status = ST_FULL;
        end else begin
          kind      = CELL_SHIFT_UP;
          count_nxt = count_r + CntW'(1);
        end
      end
      OP_ERASE: begin
        if (pos_x >= n_x) begin
          status = ST_RANGE;
        end else begin
          kind      = CELL_SHIFT_DOWN;
          count_nxt = count_r - CntW'(1);
        end
      end
      OP_READ: begin
        if (pos_x >= n_x) begin
          status = ST_RANGE;
        end else begin
          rd_en = 1'b1;
        end
      end
      OP_WRITE: begin
        if (pos_x >= n_x) begin
          status = ST_RANGE;
        end else begin
          kind = CELL_WRITE;
        end
      end
      OP_REVERSE: begin
        // fewer than two elements read the same either way
        if (n_x >= CmpW'(2)) begin
          rev_nxt = ~rev_r;
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        // unknown codes change nothing
        kind = CELL_HOLD;
      end
    endcase
  end

  assign cmd.kind = fire ? kind : CELL_HOLD;
  assign cmd.data = din;

  // row of cells; the ends feed themselves where no neighbor exists
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_v;
    logic [DATA_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = cell_val[i];
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = cell_val[i];
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end
    pss_cell #(
      .IdxW (IdxW),
      .Idx  (i)
    ) u_cell (
      .clk    (clk),
      .cmd    (cmd),
      .target (target),
      .left   (left_v),
      .right  (right_v),
      .value  (cell_val[i]),
      .rd     (cell_rd[i])
    );
  end

  // only the addressed cell drives a nonzero read value
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | cell_rd[i];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rev_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        count_r <= count_nxt;
        rev_r   <= rev_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r   <= rd_en ? rd_data : '0;
      out_count_r  <= count_nxt;
      out_status_r <= status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PadW{1'b0}}, POS_W'(out_count_r), out_data_r};
  assign out_tuser  = out_status_r;

endmodule

>>> dv/positional_sequence_store_tb.sv
module positional_sequence_store_tb;
  import pss_pkg::*;

  localparam int Capacity = DefCapacity;
  localparam int PosMax   = DefCapacity;
  localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

  localparam logic [DATA_W-1:0] MostNeg = 32'h8000_0000;
  localparam logic [DATA_W-1:0] MostPos = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] AllOnes = 32'hffff_ffff;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] data;
  } request_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  count;
    logic [ST_W-1:0]   status;
  } list_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [OP_W-1:0]        in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [ST_W-1:0]        out_tuser;

  request_t     pending_requests[$];
  list_result_t expected_results[$];
  request_t     request_on_bus;

  // shadow of the list contents, advanced once per accepted request
  logic [DATA_W-1:0] list_cells[Capacity];
  int                list_len = 0;

  // length as seen by the generator, used to aim positions
  int gen_len = 0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int mismatch_count = 0;

  positional_sequence_store dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // applies one request to the shadow list and returns the answer it must give
  function automatic list_result_t apply_request(input request_t req);
    list_result_t res;
    int p;
    logic [DATA_W-1:0] swap;
    int lo;
    int hi;
    res = '0;
    res.status = ST_DONE;
    p = req.pos;
    case (req.op)
      OP_INSERT: begin
        if (p > list_len) begin
          res.status = ST_RANGE;
        end else if (list_len >= Capacity) begin
          res.status = ST_FULL;
        end else begin
          for (int i = list_len; i > p; i--) list_cells[i] = list_cells[i-1];
          list_cells[p] = req.data;
          list_len++;
        end
      end
      OP_ERASE: begin
        if (p >= list_len) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = p; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
          list_len--;
        end
      end
      OP_READ: begin
        if (p >= list_len) res.status = ST_RANGE;
        else res.value = list_cells[p];
      end
      OP_WRITE: begin
        if (p >= list_len) res.status = ST_RANGE;
        else list_cells[p] = req.data;
      end
      OP_REVERSE: begin
        lo = 0;
        hi = list_len - 1;
        while (lo < hi) begin
          swap = list_cells[lo];
          list_cells[lo] = list_cells[hi];
          list_cells[hi] = swap;
          lo++;
          hi--;
        end
      end
      OP_CLEAR: list_len = 0;
      default: ;
    endcase
    res.count = list_len[POS_W-1:0];
    return res;
  endfunction

  // sender: one request per transfer, random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_request(request_on_bus));
      if (!in_tvalid || in_tready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          request_on_bus = pending_requests.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {1'b0, request_on_bus.data, request_on_bus.pos};
          in_tuser  <= request_on_bus.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result transfer against the oldest expectation
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, tdata %h tuser %0d",
                                    out_tdata, out_tuser));
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[DATA_W-1:0] !== want.value)
            report_mismatch($sformatf("data_out %h, expected %h",
                                      out_tdata[DATA_W-1:0], want.value));
          if (out_tdata[DATA_W+POS_W-1:DATA_W] !== want.count)
            report_mismatch($sformatf("count %0d, expected %0d",
                                      out_tdata[DATA_W+POS_W-1:DATA_W], want.count));
          if (out_tuser !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_tuser, want.status));
        end
      end
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic queue_request(input logic [OP_W-1:0] op, input int pos,
                               input logic [DATA_W-1:0] data);
    request_t req;
    req.op   = op;
    req.pos  = pos[POS_W-1:0];
    req.data = data;
    pending_requests.push_back(req);
    case (op)
      OP_INSERT: if (pos <= gen_len && gen_len < Capacity) gen_len++;
      OP_ERASE:  if (pos < gen_len) gen_len--;
      OP_CLEAR:  gen_len = 0;
      default: ;
    endcase
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] v;
    v = $urandom;
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: v = MostNeg;
        1: v = MostPos;
        2: v = '0;
        default: v = AllOnes;
      endcase
    end
    return v;
  endfunction

  // mostly positions that hit the list, favoring both ends; the rest anywhere
  function automatic int pick_position(input logic [OP_W-1:0] op);
    int top;
    top = (op == OP_INSERT) ? gen_len : gen_len - 1;
    if (top < 0 || $urandom_range(99) < 15) return $urandom_range(PosMax, 0);
    case ($urandom_range(4))
      0: return 0;
      1: return top;
      default: return $urandom_range(top, 0);
    endcase
  endfunction

  // random traffic in stretches that grow, shrink or hold the list length
  task automatic queue_random(input int n);
    int mode;
    int ins_w;
    int era_w;
    int r;
    logic [OP_W-1:0] op;
    mode = 2;
    for (int k = 0; k < n; k++) begin
      if (k % 64 == 0) mode = $urandom_range(2);
      ins_w = (mode == 0) ? 55 : (mode == 1) ? 15 : 35;
      era_w = 70 - ins_w;
      r = $urandom_range(99);
      if (r < ins_w)                   op = OP_INSERT;
      else if (r < ins_w + era_w)      op = OP_ERASE;
      else if (r < 84)                 op = OP_READ;
      else if (r < 94)                 op = OP_WRITE;
      else if (r < 98)                 op = OP_REVERSE;
      else if (r < 99)                 op = OP_CLEAR;
      else                             op = $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
      queue_request(op, pick_position(op), pick_value());
    end
  endtask

  // holds the stimulus until every queued request has been answered
  task automatic wait_drained();
    @(negedge clk);
    while (pending_requests.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    tx_idle_pct = 25;
    rx_idle_pct = 48;
    @(posedge rst_n);

    // empty list first, where every positional access is out of range; then a short list is built and edited
    queue_request(OP_READ,    0,      $urandom);
    queue_request(OP_ERASE,   0,      $urandom);
    queue_request(OP_WRITE,   0,      $urandom);
    queue_request(OP_REVERSE, 5,      $urandom);
    queue_request(OP_INSERT,  1,      $urandom);
    queue_request(OP_INSERT,  0,      MostPos);
    queue_request(OP_REVERSE, 0,      $urandom);
    queue_request(OP_INSERT,  1,      MostNeg);
    queue_request(OP_INSERT,  0,      AllOnes);
    queue_request(OP_INSERT,  PosMax, $urandom);
    queue_request(OP_READ,    0,      $urandom);
    queue_request(OP_READ,    2,      $urandom);
    queue_request(OP_REVERSE, PosMax, AllOnes);
    queue_request(OP_READ,    0,      $urandom);
    queue_request(OP_READ,    1,      $urandom);
    queue_request(OP_WRITE,   1,      '0);
    queue_request(OP_READ,    1,      $urandom);
    queue_request(OP_ERASE,   2,      $urandom);
    queue_request(OP_READ,    2,      $urandom);
    queue_request(OP_SPARE6,  PosMax, AllOnes);
    queue_request(OP_SPARE7,  0,      $urandom);
    queue_request(OP_CLEAR,   3,      $urandom);
    queue_request(OP_READ,    0,      $urandom);

    // fill to capacity, then poke the full list
    while (gen_len < Capacity) queue_request(OP_INSERT, $urandom_range(gen_len, 0), $urandom);
    queue_request(OP_INSERT,  PosMax,       $urandom);
    queue_request(OP_INSERT,  0,            $urandom);
    queue_request(OP_READ,    Capacity - 1, $urandom);
    queue_request(OP_READ,    PosMax,       $urandom);
    queue_request(OP_REVERSE, 0,            $urandom);
    queue_request(OP_READ,    0,            $urandom);
    queue_request(OP_WRITE,   PosMax,       $urandom);
    queue_request(OP_ERASE,   Capacity - 1, $urandom);
    queue_request(OP_INSERT,  PosMax,       $urandom);

    queue_random(600);
    wait_drained();

    tx_idle_pct = 48;
    rx_idle_pct = 25;
    queue_random(600);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random(600);
    wait_drained();

    repeat (10) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d requests queued and %0d results outstanding",
             pending_requests.size(), expected_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
